/* hdl/bpc_pkg.sv */
package bpc_pkg;

    localparam int COEFF_W   = 16;
    localparam int RAW_W     = 24;
    localparam int TEMP_W    = 19;
    localparam int PRES_W    = 32;
    localparam int CFG_IDX_W = 3;

    // internal widths, sized from the value ranges of the compensation math
    localparam int DT_W    = RAW_W + 1;
    localparam int CPROD_W = DT_W + COEFF_W + 1;
    localparam int DTSQ_W  = 2 * DT_W;
    localparam int OFF_W   = 40;
    localparam int SENS_W  = 40;
    localparam int SQ_W    = 36;
    localparam int CORR_W  = 40;
    localparam int SLO_W   = 20;
    localparam int SHI_W   = SENS_W - SLO_W;
    localparam int PLO_W   = RAW_W + SLO_W + 2;
    localparam int PHI_W   = RAW_W + SHI_W + 1;
    localparam int PROD_W  = 64;
    localparam int X_W     = 44;
    localparam int NSTAGE  = 8;

    localparam logic signed [TEMP_W-1:0] TEMP_REF    = 19'sd2000;
    // temp + 1500 expressed from (temp - 2000)
    localparam logic signed [TEMP_W:0]   COLD_OFFSET = 20'sd3500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [COEFF_W-1:0] c1;
        logic [COEFF_W-1:0] c2;
        logic [COEFF_W-1:0] c3;
        logic [COEFF_W-1:0] c4;
        logic [COEFF_W-1:0] c5;
        logic [COEFF_W-1:0] c6;
    } coeffs_t;

endpackage

/* hdl/baro_pressure_temp_compensation_core.sv */
// Barometric compensation core: each transaction on the input channel carries one raw
// pressure and one raw temperature conversion, and yields one transaction on the output
// channel with temperature in hundredths of a degree C and pressure in pascals, using the
// first- and second-order correction (with the extra cold term below -15.00 C). The core
// is an 8-stage pipeline: a new sample pair can be taken every cycle while the output
// is not stalled. The depth is set by the chain of dependent multiplies (coefficient
// products, squares of the temperature deviation, and the final raw pressure times
// sensitivity product, split into two 24x20 partial products).
// Every stage has its own valid bit, so bubbles are squeezed out under backpressure.
// Coefficients reset to zero and are written through the configuration channel; they
// should only be changed while no transaction is in flight.
module baro_pressure_temp_compensation_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bpc_pkg::COEFF_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bpc_pkg::RAW_W-1:0]           raw_pressure,
    input  logic [bpc_pkg::RAW_W-1:0]           raw_temperature,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bpc_pkg::TEMP_W-1:0]   temperature,
    output logic signed [bpc_pkg::PRES_W-1:0]   pressure
);

    localparam int NS = bpc_pkg::NSTAGE;

    bpc_pkg::coeffs_t coeffs;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] en;

    // stage 1
    logic signed [bpc_pkg::DT_W-1:0]    dt1_reg, dt1_next;
    logic [bpc_pkg::RAW_W-1:0]          d1_1_reg;
    // stage 2
    logic signed [bpc_pkg::CPROD_W-1:0] m6_reg, m6_next;
    logic signed [bpc_pkg::CPROD_W-1:0] m4_reg, m4_next;
    logic signed [bpc_pkg::CPROD_W-1:0] m3_reg, m3_next;
    logic signed [bpc_pkg::DTSQ_W-1:0]  mdd_reg, mdd_next;
    logic [bpc_pkg::RAW_W-1:0]          d1_2_reg;
    // stage 3
    logic signed [bpc_pkg::TEMP_W-1:0]  a3_reg, a3_next;
    logic signed [bpc_pkg::TEMP_W:0]    b3_reg, b3_next;
    logic signed [bpc_pkg::TEMP_W-1:0]  temp3_reg, temp3_next;
    logic signed [bpc_pkg::TEMP_W-1:0]  t2_3_reg, t2_3_next;
    logic signed [bpc_pkg::OFF_W-1:0]   off3_reg, off3_next;
    logic signed [bpc_pkg::SENS_W-1:0]  sens3_reg, sens3_next;
    logic [bpc_pkg::RAW_W-1:0]          d1_3_reg;
    // stage 4
    logic signed [2*bpc_pkg::TEMP_W-1:0]   asq_full;
    logic signed [2*bpc_pkg::TEMP_W+1:0]   bsq_full;
    logic [bpc_pkg::SQ_W-1:0]           sq4_reg, sq4_next;
    logic [bpc_pkg::SQ_W-1:0]           sb4_reg, sb4_next;
    logic                               low4_reg, cold4_reg;
    logic signed [bpc_pkg::TEMP_W-1:0]  temp4_reg, temp4_next;
    logic signed [bpc_pkg::OFF_W-1:0]   off4_reg;
    logic signed [bpc_pkg::SENS_W-1:0]  sens4_reg;
    logic [bpc_pkg::RAW_W-1:0]          d1_4_reg;
    // stage 5
    logic [bpc_pkg::CORR_W-1:0]         sq5x, sb7x, sb11x, off2, sens2;
    logic signed [bpc_pkg::OFF_W-1:0]   off5_reg, off5_next;
    logic signed [bpc_pkg::SENS_W-1:0]  sens5_reg, sens5_next;
    logic signed [bpc_pkg::TEMP_W-1:0]  temp5_reg;
    logic [bpc_pkg::RAW_W-1:0]          d1_5_reg;
    // stage 6
    logic signed [bpc_pkg::PLO_W-1:0]   plo6_reg, plo6_next;
    logic signed [bpc_pkg::PHI_W-1:0]   phi6_reg, phi6_next;
    logic signed [bpc_pkg::OFF_W-1:0]   off6_reg;
    logic signed [bpc_pkg::TEMP_W-1:0]  temp6_reg;
    // stage 7
    logic signed [bpc_pkg::PROD_W-1:0]  prod7;
    logic signed [bpc_pkg::X_W-1:0]     x7_reg, x7_next;
    logic signed [bpc_pkg::TEMP_W-1:0]  temp7_reg;
    // stage 8
    logic signed [bpc_pkg::PRES_W-1:0]  pres8_reg, pres8_next;
    logic signed [bpc_pkg::TEMP_W-1:0]  temp8_reg;

    bpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coeffs    (coeffs)
    );

    // a stage may load when it is empty or its content moves on
    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    assign in_ready    = en[0];
    assign out_valid   = valid_reg[NS-1];
    assign temperature = temp8_reg;
    assign pressure    = pres8_reg;

    // datapath
    always_comb
    begin
        dt1_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, coeffs.c5, 8'h00});

        m6_next  = dt1_reg * $signed({1'b0, coeffs.c6});
        m4_next  = dt1_reg * $signed({1'b0, coeffs.c4});
        m3_next  = dt1_reg * $signed({1'b0, coeffs.c3});
        mdd_next = dt1_reg * dt1_reg;

        // a = temp - 2000, b = temp + 1500
        a3_next    = m6_reg[bpc_pkg::CPROD_W-1:23];
        temp3_next = a3_next + bpc_pkg::TEMP_REF;
        b3_next    = (bpc_pkg::TEMP_W + 1)'(a3_next) + bpc_pkg::COLD_OFFSET;
        t2_3_next  = mdd_reg[bpc_pkg::DTSQ_W-1:31];
        off3_next  = $signed({8'h00, coeffs.c2, 16'h0000})
                   + bpc_pkg::OFF_W'($signed(m4_reg[bpc_pkg::CPROD_W-1:7]));
        sens3_next = $signed({9'h000, coeffs.c1, 15'h0000})
                   + bpc_pkg::SENS_W'($signed(m3_reg[bpc_pkg::CPROD_W-1:8]));

        asq_full   = a3_reg * a3_reg;
        bsq_full   = b3_reg * b3_reg;
        sq4_next   = asq_full[bpc_pkg::SQ_W-1:0];
        sb4_next   = bsq_full[bpc_pkg::SQ_W-1:0];
        temp4_next = a3_reg[bpc_pkg::TEMP_W-1] ? (temp3_reg - t2_3_reg) : temp3_reg;

        sq5x  = {2'b00, sq4_reg, 2'b00} + {4'h0, sq4_reg};
        sb7x  = {1'b0, sb4_reg, 3'b000} - {4'h0, sb4_reg};
        sb11x = {1'b0, sb4_reg, 3'b000} + {3'b000, sb4_reg, 1'b0} + {4'h0, sb4_reg};
        off2  = '0;
        sens2 = '0;
        if (low4_reg)
        begin
            off2  = (sq5x >> 1) + (cold4_reg ? sb7x : '0);
            sens2 = (sq5x >> 2) + (cold4_reg ? (sb11x >> 1) : '0);
        end
        off5_next  = off4_reg - $signed(off2);
        sens5_next = sens4_reg - $signed(sens2);

        plo6_next = $signed({1'b0, d1_5_reg}) * $signed({1'b0, sens5_reg[bpc_pkg::SLO_W-1:0]});
        phi6_next = $signed({1'b0, d1_5_reg}) * $signed(sens5_reg[bpc_pkg::SENS_W-1:bpc_pkg::SLO_W]);

        prod7   = (bpc_pkg::PROD_W'(phi6_reg) <<< bpc_pkg::SLO_W) + bpc_pkg::PROD_W'(plo6_reg);
        x7_next = bpc_pkg::X_W'($signed(prod7[bpc_pkg::PROD_W-1:21]))
                - bpc_pkg::X_W'(off6_reg);

        // |x| stays below 2^43, so the shifted value always fits and the clamp is a sign extend
        pres8_next = bpc_pkg::PRES_W'($signed(x7_reg[bpc_pkg::X_W-1:15]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dt1_reg  <= dt1_next;
            d1_1_reg <= raw_pressure;
        end
        if (en[1])
        begin
            m6_reg   <= m6_next;
            m4_reg   <= m4_next;
            m3_reg   <= m3_next;
            mdd_reg  <= mdd_next;
            d1_2_reg <= d1_1_reg;
        end
        if (en[2])
        begin
            a3_reg    <= a3_next;
            b3_reg    <= b3_next;
            temp3_reg <= temp3_next;
            t2_3_reg  <= t2_3_next;
            off3_reg  <= off3_next;
            sens3_reg <= sens3_next;
            d1_3_reg  <= d1_2_reg;
        end
        if (en[3])
        begin
            sq4_reg   <= sq4_next;
            sb4_reg   <= sb4_next;
            low4_reg  <= a3_reg[bpc_pkg::TEMP_W-1];
            cold4_reg <= b3_reg[bpc_pkg::TEMP_W];
            temp4_reg <= temp4_next;
            off4_reg  <= off3_reg;
            sens4_reg <= sens3_reg;
            d1_4_reg  <= d1_3_reg;
        end
        if (en[4])
        begin
            off5_reg  <= off5_next;
            sens5_reg <= sens5_next;
            temp5_reg <= temp4_reg;
            d1_5_reg  <= d1_4_reg;
        end
        if (en[5])
        begin
            plo6_reg  <= plo6_next;
            phi6_reg  <= phi6_next;
            off6_reg  <= off5_reg;
            temp6_reg <= temp5_reg;
        end
        if (en[6])
        begin
            x7_reg    <= x7_next;
            temp7_reg <= temp6_reg;
        end
        if (en[7])
        begin
            pres8_reg <= pres8_next;
            temp8_reg <= temp7_reg;
        end
    end

    // a full pipeline behind a stalled output takes nothing new
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && !out_ready) |-> !in_ready)
        else $error("input taken while pipeline full and stalled");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[0])
        else $error("accepted transaction did not enter first stage");

    // below -15.00 C is always also below 20.00 C
    a_cold_is_low: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[2] && b3_reg[bpc_pkg::TEMP_W]) |-> a3_reg[bpc_pkg::TEMP_W-1])
        else $error("cold flag without low temperature flag");

    a_warm_no_t2: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[2] && en[3] && !a3_reg[bpc_pkg::TEMP_W-1]) |=> temp4_reg == $past(temp3_reg))
        else $error("second-order temperature term applied above 20.00 C");

endmodule

/* hdl/bpc_cfg_regs.sv */
module bpc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpc_pkg::COEFF_W-1:0]    cfg_data,
    output bpc_pkg::coeffs_t               coeffs
);

    bpc_pkg::coeffs_t coeffs_reg;
    bpc_pkg::coeffs_t coeffs_next;

    assign cfg_ready = 1'b1;
    assign coeffs    = coeffs_reg;

    always_comb
    begin
        coeffs_next = coeffs_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                bpc_pkg::REG_C1: coeffs_next.c1 = cfg_data;
                bpc_pkg::REG_C2: coeffs_next.c2 = cfg_data;
                bpc_pkg::REG_C3: coeffs_next.c3 = cfg_data;
                bpc_pkg::REG_C4: coeffs_next.c4 = cfg_data;
                bpc_pkg::REG_C5: coeffs_next.c5 = cfg_data;
                bpc_pkg::REG_C6: coeffs_next.c6 = cfg_data;
                default:         coeffs_next    = coeffs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeffs_reg <= '0;
        end
        else
        begin
            coeffs_reg <= coeffs_next;
        end
    end

endmodule

/* test/tb_baro_pressure_temp_compensation_core.sv */
`timescale 1ns / 1ps

module tb_baro_pressure_temp_compensation_core;

    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 183;
    localparam int HOLD_LEN    = 400;
    localparam int SETTLE      = 12;
    localparam int STALL_LIMIT = 5000;

    // indexes past the register list, writes there must be dropped
    localparam logic [bpc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [bpc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [63:0] WARM_LIMIT = 64'sd2000;
    localparam logic signed [63:0] COLD_LIMIT = -64'sd1500;
    localparam logic signed [63:0] P_MAX      = 64'sd2147483647;
    localparam logic signed [63:0] P_MIN      = -64'sd2147483648;

    typedef struct {
        logic [bpc_pkg::RAW_W-1:0] d1;
        logic [bpc_pkg::RAW_W-1:0] d2;
    } raw_pair_t;

    typedef struct {
        logic signed [bpc_pkg::TEMP_W-1:0] temperature;
        logic signed [bpc_pkg::PRES_W-1:0] pressure;
    } reading_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [bpc_pkg::COEFF_W-1:0]       cfg_data  = '0;
    logic                              in_valid  = 1'b0;
    logic                              in_ready;
    logic [bpc_pkg::RAW_W-1:0]         raw_pressure    = '0;
    logic [bpc_pkg::RAW_W-1:0]         raw_temperature = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic signed [bpc_pkg::TEMP_W-1:0] temperature;
    logic signed [bpc_pkg::PRES_W-1:0] pressure;

    bpc_pkg::coeffs_t coeffs = '0;
    raw_pair_t        pending_pairs[$];
    reading_t         expected_readings[$];

    int queued_count   = 0;
    int accepted_count = 0;
    int result_count   = 0;
    int error_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    always #1 clk = ~clk;

    baro_pressure_temp_compensation_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .raw_pressure    (raw_pressure),
        .raw_temperature (raw_temperature),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .temperature     (temperature),
        .pressure        (pressure)
    );

    // first and second order compensation in 64-bit wrapping arithmetic
    function automatic reading_t compensate(input logic [bpc_pkg::RAW_W-1:0] d1,
                                            input logic [bpc_pkg::RAW_W-1:0] d2);
        logic signed [63:0] k1, k2, k3, k4, k6, dt, temp, off, sens;
        logic signed [63:0] t2, off2, sens2, dev, sq, cold, csq, p;
        reading_t r;
        k1 = $signed({48'd0, coeffs.c1});
        k2 = $signed({48'd0, coeffs.c2});
        k3 = $signed({48'd0, coeffs.c3});
        k4 = $signed({48'd0, coeffs.c4});
        k6 = $signed({48'd0, coeffs.c6});
        dt = $signed({40'd0, d2}) - $signed({40'd0, coeffs.c5, 8'd0});
        temp = WARM_LIMIT + ((dt * k6) >>> 23);
        off  = (k2 <<< 16) + ((k4 * dt) >>> 7);
        sens = (k1 <<< 15) + ((k3 * dt) >>> 8);
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        if (temp < WARM_LIMIT)
        begin
            dev   = temp - WARM_LIMIT;
            sq    = dev * dev;
            t2    = (dt * dt) >>> 31;
            off2  = (64'sd5 * sq) >>> 1;
            sens2 = (64'sd5 * sq) >>> 2;
            if (temp < COLD_LIMIT)
            begin
                cold  = temp - COLD_LIMIT;
                csq   = cold * cold;
                off2  = off2 + 64'sd7 * csq;
                sens2 = sens2 + ((64'sd11 * csq) >>> 1);
            end
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        p = ((($signed({40'd0, d1}) * sens) >>> 21) - off) >>> 15;
        if (p > P_MAX)
            p = P_MAX;
        else if (p < P_MIN)
            p = P_MIN;
        r.temperature = temp[bpc_pkg::TEMP_W-1:0];
        r.pressure    = p[bpc_pkg::PRES_W-1:0];
        return r;
    endfunction

    // sender: offers queued pairs, predicts each one as it is taken
    always @(posedge clk)
    begin : sender
        raw_pair_t nxt;
        if (in_valid && in_ready)
        begin
            expected_readings.push_back(compensate(raw_pressure, raw_temperature));
            accepted_count++;
        end
        if (!in_valid || in_ready)
        begin
            if (rst_n && pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_pairs.pop_front();
                in_valid        <= 1'b1;
                raw_pressure    <= nxt.d1;
                raw_temperature <= nxt.d2;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks each result transaction against the oldest prediction
    always @(posedge clk)
    begin : receiver
        reading_t want;
        if (out_valid && out_ready)
        begin
            if (expected_readings.size() == 0)
            begin
                $error("unexpected result: temperature %0d, pressure %0d", temperature, pressure);
                error_count++;
            end
            else
            begin
                want = expected_readings.pop_front();
                result_count++;
                if (temperature !== want.temperature)
                begin
                    $error("temperature mismatch: expected %0d, actual %0d",
                           want.temperature, temperature);
                    error_count++;
                end
                if (pressure !== want.pressure)
                begin
                    $error("pressure mismatch: expected %0d, actual %0d",
                           want.pressure, pressure);
                    error_count++;
                end
            end
        end
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_requests != hold_served)
        begin
            hold_served++;
            hold_left = HOLD_LEN;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic cfg_write(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bpc_pkg::COEFF_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (bpc_pkg::cfg_reg_t'(idx))
            bpc_pkg::REG_C1: coeffs.c1 = data;
            bpc_pkg::REG_C2: coeffs.c2 = data;
            bpc_pkg::REG_C3: coeffs.c3 = data;
            bpc_pkg::REG_C4: coeffs.c4 = data;
            bpc_pkg::REG_C5: coeffs.c5 = data;
            bpc_pkg::REG_C6: coeffs.c6 = data;
            default: ;
        endcase
    endtask

    task automatic load_coeffs(input bpc_pkg::coeffs_t s);
        cfg_write(bpc_pkg::REG_C1, s.c1);
        cfg_write(bpc_pkg::REG_C2, s.c2);
        cfg_write(bpc_pkg::REG_C3, s.c3);
        cfg_write(bpc_pkg::REG_C4, s.c4);
        cfg_write(bpc_pkg::REG_C5, s.c5);
        cfg_write(bpc_pkg::REG_C6, s.c6);
        cfg_write($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                  bpc_pkg::COEFF_W'($urandom));
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || result_count != accepted_count)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic queue_pair(input logic [bpc_pkg::RAW_W-1:0] d1,
                              input logic [bpc_pkg::RAW_W-1:0] d2);
        raw_pair_t s;
        s.d1 = d1;
        s.d2 = d2;
        pending_pairs.push_back(s);
        queued_count++;
    endtask

    task automatic queue_corners();
        queue_pair('0, '0);
        queue_pair('1, '0);
        queue_pair('0, '1);
        queue_pair('1, '1);
    endtask

    function automatic logic [bpc_pkg::COEFF_W-1:0] rand_coeff();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return bpc_pkg::COEFF_W'($urandom);
        endcase
    endfunction

    task automatic queue_random_pair();
        int v, dv;
        logic [bpc_pkg::RAW_W-1:0] d1, d2;
        d1 = bpc_pkg::RAW_W'($urandom);
        case ($urandom_range(3))
            0: d2 = bpc_pkg::RAW_W'($urandom);
            1:
            begin
                // near the reference temperature, where the corrections switch in
                v  = {coeffs.c5, 8'd0};
                dv = $urandom_range(0, 1 << $urandom_range(4, 21));
                v  = $urandom_range(1) ? v + dv : v - dv;
                if (v < 0)
                    v = 0;
                else if (v > 24'hFFFFFF)
                    v = 24'hFFFFFF;
                d2 = v[bpc_pkg::RAW_W-1:0];
            end
            2:
            begin
                d2 = $urandom_range(1) ? bpc_pkg::RAW_W'($urandom_range(0, 255))
                                       : bpc_pkg::RAW_W'(24'hFFFFFF - $urandom_range(0, 255));
                if ($urandom_range(1))
                    d1 = $urandom_range(1) ? '1 : '0;
            end
            default:
            begin
                d2 = bpc_pkg::RAW_W'($urandom);
                d1 = bpc_pkg::RAW_W'($urandom_range(0, 1 << $urandom_range(0, 23)));
            end
        endcase
        queue_pair(d1, d2);
    endtask

    initial
    begin : stimulus
        bpc_pkg::coeffs_t setting;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 69;

        // c5 and c6 at 2^15 make temp = 2000 + (d2 - 2^23) / 256, so edges land exactly
        setting = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd32768, 16'd32768};
        load_coeffs(setting);
        queue_pair(24'd0,       24'h800000);
        queue_pair(24'hFFFFFF,  24'h8000FF);
        queue_pair(24'd9085466, 24'h7FFFFF);
        queue_pair(24'd9085466, 24'h7FFF00);
        queue_pair(24'hFFFFFF,  24'd7492608);
        queue_pair(24'd9085466, 24'd7492607);
        queue_pair(24'hFFFFFF,  24'd0);
        queue_pair(24'd1,       24'hFFFFFF);
        wait_drained();

        setting = '1;
        load_coeffs(setting);
        queue_corners();
        wait_drained();

        setting = '0;
        load_coeffs(setting);
        queue_corners();
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph < 4)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 69;
            end
            else if (ph < 8)
            begin
                send_idle_pct = 69;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 0)
            begin
                setting = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
            end
            else
            begin
                setting = '{rand_coeff(), rand_coeff(), rand_coeff(),
                            rand_coeff(), rand_coeff(), rand_coeff()};
            end
            load_coeffs(setting);
            if (ph == 0)
                queue_pair(24'd9085466, 24'd8569150);
            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_random_pair();
            // output held off while the sender keeps offering, so the pipeline backs up
            if (ph == 2 || ph == 9)
                hold_requests++;
            wait_drained();
        end

        repeat (SETTLE) @(posedge clk);
        if (error_count == 0 && expected_readings.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
